// ----- hdl/dwks_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwks_pkg
// Shared types and constants of the dual watchdog kick supervisor.
// ----------------------------------------------------------------------------
package dwks_pkg;

    // command codes of an input beat
    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_INIT       = 3'd0;
    localparam t_cmd CMD_FINALIZE   = 3'd1;
    localparam t_cmd CMD_START      = 3'd2;
    localparam t_cmd CMD_STOP       = 3'd3;
    localparam t_cmd CMD_TERMINATE  = 3'd4;
    localparam t_cmd CMD_KEEPALIVE  = 3'd5;
    localparam t_cmd CMD_HEARTBEAT  = 3'd6;
    localparam t_cmd CMD_HB_TIMEOUT = 3'd7;

    // run state codes
    typedef logic [1:0] t_run;
    localparam t_run RS_READY   = 2'd0;
    localparam t_run RS_STOPPED = 2'd1;
    localparam t_run RS_STARTED = 2'd2;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FIRST_TIMEOUT  = 2'd0;
    localparam t_cfg_idx CFG_SECOND_TIMEOUT = 2'd1;
    localparam t_cfg_idx CFG_KICK_PERIOD    = 2'd2;

    localparam int CFG_BITS = 16;
    localparam logic [CFG_BITS-1:0] FIRST_TIMEOUT_RST  = 16'd120;
    localparam logic [CFG_BITS-1:0] SECOND_TIMEOUT_RST = 16'd180;
    localparam logic [CFG_BITS-1:0] KICK_PERIOD_RST    = 16'd10;

    // margin before a watchdog expires for its final kick
    localparam logic [CFG_BITS-1:0] GRACE_SEC = 16'd60;

    localparam int NOW_BITS = 32;

    typedef struct packed {
        logic [CFG_BITS-1:0] first_timeout_sec;
        logic [CFG_BITS-1:0] second_timeout_sec;
        logic [CFG_BITS-1:0] kick_period_sec;
    } t_cfg;

    typedef struct packed {
        logic kick_first;
        logic kick_second;
        logic status;
        t_run run_state_out;
    } t_res;

endpackage

// ----- hdl/dwks_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwks_in_if
// Input channel: command and seconds timestamp with valid/ready.
// ----------------------------------------------------------------------------
interface dwks_in_if
    import dwks_pkg::*;
;
    logic                valid;
    logic                ready;
    t_cmd                cmd;
    logic [NOW_BITS-1:0] now_sec;

    modport source (output valid, output cmd, output now_sec, input ready);
    modport sink   (input valid, input cmd, input now_sec, output ready);
endinterface

// ----- hdl/dwks_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwks_out_if
// Result channel: kick flags, status and run state with valid/ready.
// ----------------------------------------------------------------------------
interface dwks_out_if
    import dwks_pkg::*;
;
    logic valid;
    logic ready;
    logic kick_first;
    logic kick_second;
    logic status;
    t_run run_state_out;

    modport source (output valid, output kick_first, output kick_second,
                    output status, output run_state_out, input ready);
    modport sink   (input valid, input kick_first, input kick_second,
                    input status, input run_state_out, output ready);
endinterface

// ----- hdl/dwks_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwks_cfg_regs
// Timeout and kick period registers behind a plain write port.
// ----------------------------------------------------------------------------
module dwks_cfg_regs
    import dwks_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    // register write decode, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_timeout_sec  <= FIRST_TIMEOUT_RST;
            r_cfg.second_timeout_sec <= SECOND_TIMEOUT_RST;
            r_cfg.kick_period_sec    <= KICK_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_TIMEOUT:  r_cfg.first_timeout_sec  <= i_cfg_data;
                CFG_SECOND_TIMEOUT: r_cfg.second_timeout_sec <= i_cfg_data;
                CFG_KICK_PERIOD:    r_cfg.kick_period_sec    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/dwks_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwks_core
// Supervisor state and the per-command decision logic for one beat.
// ----------------------------------------------------------------------------
module dwks_core
    import dwks_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_cmd                 i_cmd,
    input  logic [TIME_BITS-1:0] i_now,
    input  t_cfg                 i_cfg,
    output t_res                 o_res
);

    t_run                        r_run,  n_run;
    logic                        r_halt, n_halt;
    logic                        r_lost, n_lost;
    logic [TIME_BITS-1:0]        r_hb,   n_hb;
    logic [1:0][TIME_BITS-1:0]   r_kick, n_kick;
    logic [1:0]                  r_over, n_over;

    logic [1:0]                  kick;
    logic                        err;
    logic [TIME_BITS-1:0]        gap;
    logic [1:0][TIME_BITS-1:0]   since;
    logic [1:0][TIME_BITS-1:0]   thresh;
    logic [1:0][CFG_BITS-1:0]    tout;
    logic [TIME_BITS-1:0]        period;

    // thresholds saturate at zero, differences wrap at the time width
    always_comb begin
        tout[0] = i_cfg.first_timeout_sec;
        tout[1] = i_cfg.second_timeout_sec;
        for (int i = 0; i < 2; i++) begin
            thresh[i] = (tout[i] > GRACE_SEC) ? TIME_BITS'(tout[i] - GRACE_SEC) : '0;
            since[i]  = i_now - r_kick[i];
        end
        period = TIME_BITS'(i_cfg.kick_period_sec);
        // the first timeout takes now as heartbeat time, so the gap is zero
        gap    = r_lost ? (i_now - r_hb) : '0;
    end

    // next state and kicks for the current beat
    always_comb begin
        n_run  = r_run;
        n_halt = r_halt;
        n_lost = r_lost;
        n_hb   = r_hb;
        n_kick = r_kick;
        n_over = r_over;
        kick   = '0;
        err    = 1'b0;
        unique case (i_cmd)
            CMD_INIT: begin
                if (r_run != RS_READY) begin
                    err = 1'b1;
                end else begin
                    n_halt = 1'b0;
                    n_over = '0;
                    n_lost = 1'b0;
                    n_run  = RS_STOPPED;
                end
            end
            CMD_FINALIZE: begin
                if (r_run == RS_READY) begin
                    err = 1'b1;
                end else begin
                    n_halt = 1'b1;
                    n_run  = RS_READY;
                end
            end
            CMD_START: begin
                if (r_run != RS_STOPPED) begin
                    err = 1'b1;
                end else begin
                    n_kick[0] = i_now;
                    n_kick[1] = i_now;
                    n_hb      = i_now;
                    n_run     = RS_STARTED;
                end
            end
            CMD_STOP: begin
                if (r_run != RS_STARTED) begin
                    err = 1'b1;
                end else begin
                    n_run = RS_STOPPED;
                end
            end
            CMD_TERMINATE: begin
                if (r_run != RS_STARTED) begin
                    err = 1'b1;
                end else begin
                    n_halt = 1'b1;
                end
            end
            CMD_KEEPALIVE: begin
                kick      = 2'b11;
                n_kick[0] = i_now;
                n_kick[1] = i_now;
                n_hb      = i_now;
                n_over    = '0;
            end
            CMD_HEARTBEAT: begin
                if (r_run != RS_STARTED) begin
                    err = 1'b1;
                end else if (!r_halt) begin
                    n_lost = 1'b0;
                    n_over = '0;
                    n_hb   = i_now;
                    // routine kicks, overdue just cleared
                    for (int i = 0; i < 2; i++) begin
                        if (since[i] >= period) begin
                            kick[i]   = 1'b1;
                            n_kick[i] = i_now;
                        end
                    end
                end
            end
            CMD_HB_TIMEOUT: begin
                if (r_run != RS_STARTED) begin
                    err = 1'b1;
                end else if (!r_halt) begin
                    if (!r_lost) begin
                        n_hb   = i_now;
                        n_lost = 1'b1;
                    end
                    for (int i = 0; i < 2; i++) begin
                        if (gap >= thresh[i]) begin
                            // one final kick, then the watchdog is left alone
                            if (!r_over[i]) begin
                                kick[i]   = 1'b1;
                                n_kick[i] = i_now;
                            end
                            n_over[i] = 1'b1;
                        end else if (!r_over[i] && since[i] >= period) begin
                            kick[i]   = 1'b1;
                            n_kick[i] = i_now;
                        end
                    end
                end
            end
        endcase
    end

    // state update on each processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= RS_READY;
            r_halt <= 1'b0;
            r_lost <= 1'b0;
            r_over <= '0;
            r_hb   <= '0;
            r_kick <= '0;
        end else if (i_en) begin
            r_run  <= n_run;
            r_halt <= n_halt;
            r_lost <= n_lost;
            r_over <= n_over;
            r_hb   <= n_hb;
            r_kick <= n_kick;
        end
    end

    assign o_res.kick_first    = kick[0];
    assign o_res.kick_second   = kick[1];
    assign o_res.status        = err;
    assign o_res.run_state_out = n_run;

    // rejected commands leave the state alone
    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && err) |=> ($stable(r_run) && $stable(r_halt) && $stable(r_lost)
                           && $stable(r_over) && $stable(r_hb)))
        else $error("state changed on a rejected command");

    // an overdue watchdog zero gets no further kick from a timeout
    a_overdue_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_cmd == CMD_HB_TIMEOUT && r_over[0]) |-> !kick[0])
        else $error("overdue watchdog zero kicked on timeout");

    // keepalive restarts all timing
    a_keepalive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_cmd == CMD_KEEPALIVE) |=>
            (r_over == 2'b00 && r_hb == $past(i_now) && r_kick[1] == $past(i_now)))
        else $error("keepalive did not restart timing");

endmodule

// ----- hdl/dual_watchdog_kick_supervisor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_watchdog_kick_supervisor
// Feeds two watchdogs from a stream of lifecycle and heartbeat events.
// ----------------------------------------------------------------------------
// Takes one event beat per clock when the result side is not stalled and
// gives exactly one result beat for it: the beat is captured in an input
// register, decided in a single pass of subtract and compare logic against
// the supervisor state, and held in an output register. State is updated in
// that same pass, so back-to-back beats see each other's effects and the
// sustained rate is one beat per cycle unless stalled. A stalled result side
// stops the input after the input register fills. Configuration writes are
// meant for idle periods; there is no clearing pass after reset.
module dual_watchdog_kick_supervisor
    import dwks_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dwks_in_if.sink             i_item,
    dwks_out_if.source          o_res,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    localparam int NB = (TIME_BITS < NOW_BITS) ? TIME_BITS : NOW_BITS;

    logic                 r_s1_valid;
    t_cmd                 r_s1_cmd;
    logic [TIME_BITS-1:0] r_s1_now;
    logic [TIME_BITS-1:0] now_t;
    logic                 r_out_valid;
    t_res                 r_res;
    t_res                 core_res;
    t_cfg                 cfg;
    logic                 adv;
    logic                 take;

    // stage advance and input acceptance
    assign adv  = !r_out_valid || o_res.ready;
    assign take = i_item.valid && i_item.ready;
    assign i_item.ready = !r_s1_valid || adv;

    // timestamp reduced or extended to the time width
    always_comb begin
        now_t         = '0;
        now_t[NB-1:0] = i_item.now_sec[NB-1:0];
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_cmd <= i_item.cmd;
            r_s1_now <= now_t;
        end
    end

    dwks_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    dwks_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_s1_valid && adv),
        .i_cmd   (r_s1_cmd),
        .i_now   (r_s1_now),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_res <= core_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.kick_first    = r_res.kick_first;
    assign o_res.kick_second   = r_res.kick_second;
    assign o_res.status        = r_res.status;
    assign o_res.run_state_out = r_res.run_state_out;

    // a beat in the input register is never dropped while the output stalls
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> r_s1_valid)
        else $error("input beat lost under stall");

    // a processed beat always shows up as a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && adv) |=> r_out_valid)
        else $error("processed beat gave no result");

    // the input register only refills when the output side moves or it is empty
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |-> !i_item.ready)
        else $error("input accepted over a held beat");

endmodule
